// File: hdl/r2e_pkg.sv
`default_nettype none
package r2e_pkg;
    localparam int DataWidth    = 16;
    localparam int CordicStages = 16;
    localparam int TabLen       = 30;
    localparam int ZW           = 35;

    localparam logic signed [ZW-1:0] HalfPiQ30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] PiQ30     = 35'sd3373259426;
    localparam logic [29:0]          InvGainQ30 = 30'd652032874;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return ZW'(signed'({1'b0, v}));
    endfunction
endpackage
`default_nettype wire

// File: hdl/r2e_cell.sv
`default_nettype none
// One CORDIC vectoring micro-rotation, registered, with enable.
module r2e_cell #(
    parameter int XW    = 20,
    parameter int SHIFT = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [XW-1:0]          i_x,
    input  wire logic signed [XW-1:0]          i_y,
    input  wire logic signed [r2e_pkg::ZW-1:0] i_z,
    output logic signed [XW-1:0]               o_x,
    output logic signed [XW-1:0]               o_y,
    output logic signed [r2e_pkg::ZW-1:0]      o_z
);
    import r2e_pkg::*;
    localparam logic signed [ZW-1:0] Ang = atan_tab(SHIFT);
    logic signed [XW-1:0] xs, ys;
    assign xs = i_x >>> SHIFT;
    assign ys = i_y >>> SHIFT;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[XW-1]) begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
                o_z <= i_z + Ang;
            end else begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
                o_z <= i_z - Ang;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/r2e_chain.sv
`default_nettype none
// Pre-rotation followed by a row of CORDIC cells; one vector per cycle while i_en is high.
module r2e_chain #(
    parameter int DATA_WIDTH    = r2e_pkg::DataWidth,
    parameter int CORDIC_STAGES = r2e_pkg::CordicStages
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [DATA_WIDTH+1:0]  i_x,
    input  wire logic signed [DATA_WIDTH+1:0]  i_y,
    output logic signed [DATA_WIDTH+3:0]       o_x,
    output logic signed [r2e_pkg::ZW-1:0]      o_z
);
    import r2e_pkg::*;
    localparam int XW = DATA_WIDTH + 4;
    localparam int NS = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;

    logic signed [XW-1:0] cx [NS+1];
    logic signed [XW-1:0] cy [NS+1];
    logic signed [ZW-1:0] cz [NS+1];
    logic signed [XW-1:0] px, py;
    logic signed [ZW-1:0] pz;
    logic                 zero;

    always_comb begin
        px = XW'(i_x);
        py = XW'(i_y);
        pz = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                px = XW'(i_y);
                py = -XW'(i_x);
                pz = HalfPiQ30;
            end else begin
                px = -XW'(i_y);
                py = XW'(i_x);
                pz = -HalfPiQ30;
            end
        end
        zero = (i_x == 0) && (i_y == 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            cx[0] <= zero ? '0 : px;
            cy[0] <= zero ? '0 : py;
            cz[0] <= zero ? '0 : pz;
        end
    end

    // A zero vector stays at zero through every cell with z = sum of +tab, so
    // its angle is forced by a flag that travels alongside.
    logic r_zero [NS+1];
    always_ff @(posedge i_clk) begin
        if (i_en) r_zero[0] <= zero;
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        r2e_cell #(.XW(XW), .SHIFT(g)) u_cell (
            .i_clk (i_clk), .i_en(i_en),
            .i_x   (cx[g]), .i_y(cy[g]), .i_z(cz[g]),
            .o_x   (cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) r_zero[g+1] <= r_zero[g];
        end
    end

    assign o_x = cx[NS];
    assign o_z = r_zero[NS] ? '0 : cz[NS];
endmodule
`default_nettype wire

// File: hdl/rotation_to_euler_angles.sv
`default_nettype none
// Throughput: one request per cycle unless stalled; two CORDIC cell rows in
// series, the second fed by the magnitude of the first, five chains in all.
// The whole pipeline advances when the output is empty or taken.
// Reset (synchronous, active low) clears valid flags and sets threshold to 1.
module rotation_to_euler_angles #(
    parameter int DATA_WIDTH    = r2e_pkg::DataWidth,
    parameter int CORDIC_STAGES = r2e_pkg::CordicStages
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [DATA_WIDTH-3:0]        i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m13,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    input  wire logic signed [DATA_WIDTH-1:0] i_m31,
    input  wire logic signed [DATA_WIDTH-1:0] i_m32,
    input  wire logic signed [DATA_WIDTH-1:0] i_m33,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_yaw,
    output logic signed [DATA_WIDTH-1:0]      o_pitch,
    output logic signed [DATA_WIDTH-1:0]      o_roll,
    output logic                              o_gimbal_locked
);
    import r2e_pkg::*;
    localparam int DW  = DATA_WIDTH;
    localparam int NS  = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
    localparam int L1  = NS + 1;
    localparam int LAT = 2 * L1 + 2;
    localparam int SH  = 33 - DW;
    localparam int MW  = DW + 34;
    localparam logic signed [ZW-1:0] Lim = ZW'((PiQ30 + (ZW'(1) <<< (SH - 1))) >>> SH);

    logic en;
    logic [LAT-1:0] r_vld, n_vld;
    logic [DW-3:0] r_thr;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_comb begin
        n_vld = r_vld;
        if (en) n_vld = {r_vld[LAT-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= (DW-2)'(1);
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
        end
    end

    // First row: all four candidate vectors in parallel
    logic signed [DW+3:0] ax, bx, cx_, dx;
    logic signed [ZW-1:0] az, bz, cz, dz;
    r2e_chain #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_x((DW+2)'(i_m33)), .i_y((DW+2)'(i_m31)),
        .o_x(ax), .o_z(az));
    r2e_chain #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_x((DW+2)'(i_m22)), .i_y((DW+2)'(i_m12)),
        .o_x(bx), .o_z(bz));
    r2e_chain #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_lyaw (
        .i_clk(i_clk), .i_en(en), .i_x((DW+2)'(i_m11)), .i_y(-(DW+2)'(i_m13)),
        .o_x(cx_), .o_z(cz));
    r2e_chain #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_lpitch (
        .i_clk(i_clk), .i_en(en), .i_x((DW+2)'(i_m22)), .i_y(-(DW+2)'(i_m32)),
        .o_x(dx), .o_z(dz));

    // Delay -m32 alongside first row
    logic signed [DW+1:0] r_nm32 [L1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm32[0] <= -(DW+2)'(i_m32);
            for (int k = 1; k < L1; k++) r_nm32[k] <= r_nm32[k-1];
        end
    end

    // Magnitude stage: multiply, register
    logic [DW+3:0] ux;
    logic [MW-1:0] r_prod;
    logic signed [ZW-1:0] r_az, r_bz, r_cz, r_dz;
    logic signed [DW+1:0] r_nm;
    assign ux = (ax > 0) ? ax : '0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= MW'(ux) * MW'(InvGainQ30) + (MW'(1) << 29);
            r_az <= az; r_bz <= bz; r_cz <= cz; r_dz <= dz; r_nm <= r_nm32[L1-1];
        end
    end
    logic [DW+3:0] mag;
    logic          lock;
    assign mag  = r_prod[DW+33:30];
    assign lock = !(mag > (DW+4)'(r_thr));

    // Second row: pitch from magnitude
    logic signed [DW+3:0] ex;
    logic signed [ZW-1:0] ez;
    r2e_chain #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_x((DW+2)'(signed'({1'b0, mag[DW:0]}))),
        .i_y(r_nm), .o_x(ex), .o_z(ez));

    logic signed [ZW-1:0] r_yz [L1], r_rz [L1], r_lpz [L1];
    logic                 r_lk [L1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yz[0]  <= lock ? r_cz : r_az;
            r_rz[0]  <= lock ? '0 : r_bz;
            r_lpz[0] <= r_dz;
            r_lk[0]  <= lock;
            for (int k = 1; k < L1; k++) begin
                r_yz[k] <= r_yz[k-1]; r_rz[k] <= r_rz[k-1];
                r_lpz[k] <= r_lpz[k-1]; r_lk[k] <= r_lk[k-1];
            end
        end
    end

    function automatic logic signed [DW-1:0] to_out(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] a;
        a = (z + (ZW'(1) <<< (SH - 1))) >>> SH;
        if (a > Lim) a = Lim;
        if (a < -Lim) a = -Lim;
        return a[DW-1:0];
    endfunction

    logic signed [ZW-1:0] pz;
    assign pz = r_lk[L1-1] ? r_lpz[L1-1] : ez;
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_yaw           <= to_out(r_yz[L1-1]);
            o_pitch         <= to_out(pz);
            o_roll          <= to_out(r_rz[L1-1]);
            o_gimbal_locked <= r_lk[L1-1];
        end
    end

    logic unused;
    assign unused = ^{bx, cx_, dx, ex, r_prod[29:0], mag[DW+3:DW+1]};

    a_lock_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gimbal_locked |-> o_roll == '0) else $error("roll not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_yaw)) else $error("output moved");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("needless stall");
endmodule
`default_nettype wire
